// File: sv/bq_pkg.sv
// shared constants, types and register codes for the biquad filter
package bq_pkg;

   // default widths of the sample and of the coefficient fraction
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 22;

   // integer bits of a coefficient including sign (q3.22 -> 26 bits)
   localparam int COEF_INT_BITS = 4;

   // queue between the feedforward front and the feedback back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // configuration register index codes
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_B0 = 3'd0,
      CSR_COEF_B1 = 3'd1,
      CSR_COEF_B2 = 3'd2,
      CSR_COEF_A1 = 3'd3,
      CSR_COEF_A2 = 3'd4
   } csr_index_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

endpackage

// File: sv/bq_fifo.sv
// short flip-flop queue carrying feedforward sums from front to back
module bq_fifo import bq_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output queue_status_type        status
);

   logic [WIDTH-1:0]     entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

// File: sv/bq_front.sv
// front: accepts samples, keeps input history, forms the feedforward sum
module bq_front import bq_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   localparam int COEF_W = COEF_FRAC_BITS + COEF_INT_BITS,
   localparam int FF_W   = SAMPLE_BITS + COEF_W + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic signed [COEF_W-1:0]      coef_b0,
   input  logic signed [COEF_W-1:0]      coef_b1,
   input  logic signed [COEF_W-1:0]      coef_b2,
   input  queue_status_type              queue_status,
   output logic                          push,
   output logic signed [FF_W-1:0]        push_data
);

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int OCC_BITS = QCNT_BITS + 2;

   logic                          accept;
   logic [OCC_BITS-1:0]           occupancy;

   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_BITS-1:0] x2_ff, x2_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0]      p0_ff, p0_in;
   logic signed [PROD_W-1:0]      p1_ff, p1_in;
   logic signed [PROD_W-1:0]      p2_ff, p2_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic signed [FF_W-1:0]        sum_ff, sum_in;

   // queue slots already promised to items in the two stages
   assign occupancy = OCC_BITS'(queue_status.count) + OCC_BITS'(s1_valid_ff)
                    + OCC_BITS'(s2_valid_ff);
   assign req_ready = (occupancy < OCC_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   // input history shifts on every accepted transaction
   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      if (accept) begin
         x1_in = req_sample_in;
         x2_in = x1_ff;
      end
   end

   // stage 1: three feedforward products
   always_comb begin
      s1_valid_in = accept;
      p0_in       = PROD_W'(coef_b0) * PROD_W'(req_sample_in);
      p1_in       = PROD_W'(coef_b1) * PROD_W'(x1_ff);
      p2_in       = PROD_W'(coef_b2) * PROD_W'(x2_ff);
   end

   // stage 2: sum of the products
   always_comb begin
      s2_valid_in = s1_valid_ff;
      sum_in      = FF_W'(p0_ff) + FF_W'(p1_ff) + FF_W'(p2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff       <= '0;
         x2_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         x1_ff       <= x1_in;
         x2_ff       <= x2_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      sum_ff <= sum_in;
   end

   assign push      = s2_valid_ff;
   assign push_data = sum_ff;

endmodule

// File: sv/bq_back.sv
// back: feedback products, final sum, rounding, saturation, output register
module bq_back import bq_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   localparam int COEF_W = COEF_FRAC_BITS + COEF_INT_BITS,
   localparam int FF_W   = SAMPLE_BITS + COEF_W + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  queue_status_type              queue_status,
   input  logic signed [FF_W-1:0]        pop_data,
   output logic                          pop,
   input  logic signed [COEF_W-1:0]      coef_a1,
   input  logic signed [COEF_W-1:0]      coef_a2,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int ACC_W  = PROD_W + 3;

   localparam logic signed [ACC_W-1:0] HALF =
      ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

   logic                          finish;
   logic signed [ACC_W-1:0]       acc;
   logic signed [ACC_W-1:0]       rounded;
   logic signed [SAMPLE_BITS-1:0] y_sat;

   logic                          busy_ff, busy_in;
   logic signed [FF_W-1:0]        ff_hold_ff, ff_hold_in;
   logic signed [PROD_W-1:0]      fb1_ff, fb1_in;
   logic signed [PROD_W-1:0]      fb2_ff, fb2_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in;
   logic signed [SAMPLE_BITS-1:0] y2_ff, y2_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   // take a new transaction only once the last output is in the history
   assign pop    = !busy_ff && !queue_status.empty;
   assign finish = busy_ff && (!rsp_valid_ff || rsp_ready);

   // final sum, round half up, clamp to the sample range
   always_comb begin
      acc     = ACC_W'(ff_hold_ff) - ACC_W'(fb1_ff) - ACC_W'(fb2_ff);
      rounded = (acc + HALF) >>> COEF_FRAC_BITS;
      if (rounded > SAT_MAX) begin
         y_sat = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rounded < SAT_MIN) begin
         y_sat = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         y_sat = rounded[SAMPLE_BITS-1:0];
      end
   end

   // two-step loop: feedback products, then sum and output history
   always_comb begin
      busy_in      = busy_ff;
      ff_hold_in   = ff_hold_ff;
      fb1_in       = fb1_ff;
      fb2_in       = fb2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         busy_in    = 1'b1;
         ff_hold_in = pop_data;
         fb1_in     = PROD_W'(coef_a1) * PROD_W'(y1_ff);
         fb2_in     = PROD_W'(coef_a2) * PROD_W'(y2_ff);
      end
      if (finish) begin
         busy_in      = 1'b0;
         y1_in        = y_sat;
         y2_in        = y1_ff;
         rsp_valid_in = 1'b1;
         rsp_data_in  = y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ff_hold_ff  <= ff_hold_in;
      fb1_ff      <= fb1_in;
      fb2_ff      <= fb2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

// File: sv/biquad_iir_filter_top.sv
// top level of the direct form I biquad filter
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid/req_ready    req_sample_in (signed sample)
//   rsp_*        out   rsp_valid/rsp_ready    rsp_sample_out (signed sample)
//   csr_*        in    csr_wr_en              csr_index, csr_wdata (coefficient)
//
// the back pops no new transaction until the last leaves its feedback loop:
// a1*y1 and a2*y2 products are registered, then sum/round/saturate follow.
// path to rsp_valid: stage 1/2, queue, feedback products, output register.
// reset clears the sample history, the coefficients and all valid state.
// the front keeps accepting while results stall, until the 4-entry queue is
// promised out; rsp_ready low holds the back with its result registered.
module biquad_iir_filter_top import bq_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   localparam int COEF_W = COEF_FRAC_BITS + COEF_INT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COEF_W-1:0]             csr_wdata
);

   localparam int FF_W = SAMPLE_BITS + COEF_W + 2;

   logic signed [COEF_W-1:0] b0_ff, b0_in;
   logic signed [COEF_W-1:0] b1_ff, b1_in;
   logic signed [COEF_W-1:0] b2_ff, b2_in;
   logic signed [COEF_W-1:0] a1_ff, a1_in;
   logic signed [COEF_W-1:0] a2_ff, a2_in;

   queue_status_type         queue_status;
   logic                     push;
   logic signed [FF_W-1:0]   push_data;
   logic                     pop;
   logic [FF_W-1:0]          pop_data;

   // coefficient register decode, unknown indexes are ignored
   always_comb begin
      b0_in = b0_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_B0: b0_in = csr_wdata;
            CSR_COEF_B1: b1_in = csr_wdata;
            CSR_COEF_B2: b2_in = csr_wdata;
            CSR_COEF_A1: a1_in = csr_wdata;
            CSR_COEF_A2: a2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= '0;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else begin
         b0_ff <= b0_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
      end
   end

   // feedforward front
   bq_front #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .coef_b0       (b0_ff),
      .coef_b1       (b1_ff),
      .coef_b2       (b2_ff),
      .queue_status  (queue_status),
      .push          (push),
      .push_data     (push_data)
   );

   // queue between front and back
   bq_fifo #(
      .WIDTH (FF_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // feedback back
   bq_back #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .pop_data       (pop_data),
      .pop            (pop),
      .coef_a1        (a1_ff),
      .coef_a2        (a2_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
